### rtl/core/shie_pkg.sv
package shie_pkg;

   // Field widths of the two channels.
   localparam int COEFF_W   = 24;
   localparam int NORMAL_W  = 16;
   localparam int INDEX_W   = 4;
   localparam int IRR_W     = 23;
   localparam int NUM_COEFF = 9;

   // Unit normal components are signed Q1.14.
   localparam int FRAC_W = 14;
   localparam int UNIT_W = FRAC_W + 2;

   // Band weights are Q.16 and fit in 18 signed bits.
   localparam int CONST_FRAC = 16;
   localparam int WEIGHT_W   = 18;

   // Normalizer geometry: the sum of squares is scaled into [2^58, 2^60).
   localparam int SUMSQ_W     = 2 * NORMAL_W;
   localparam int SCALED_W    = 60;
   localparam int ROOT_W      = SCALED_W / 2;
   localparam int QUO_W       = FRAC_W + 1;
   localparam int SHIFT_STEPS = 5;
   localparam int NORM_LAT    = 1 + SHIFT_STEPS + ROOT_W + QUO_W + 1;

   // Item kinds.
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_EVAL = 1'b1;

   // Irradiance polynomial constants, signed Q1.16.
   localparam logic signed [WEIGHT_W-1:0] K_C1  = 18'sd28118;
   localparam logic signed [WEIGHT_W-1:0] K_2C1 = 18'sd56236;
   localparam logic signed [WEIGHT_W-1:0] K_2C2 = 18'sd67064;
   localparam logic signed [WEIGHT_W-1:0] K_C3  = 18'sd48701;
   localparam logic signed [WEIGHT_W-1:0] K_C4  = 18'sd58080;
   localparam logic signed [WEIGHT_W-1:0] K_C5  = 18'sd16234;

   localparam logic [IRR_W-1:0] IRR_MAX = {IRR_W{1'b1}};

   typedef struct packed {
      logic                      kind;
      logic [INDEX_W-1:0]        coeff_index;
      logic signed [COEFF_W-1:0] coeff_red;
      logic signed [COEFF_W-1:0] coeff_green;
      logic signed [COEFF_W-1:0] coeff_blue;
      logic signed [NORMAL_W-1:0] normal_x;
      logic signed [NORMAL_W-1:0] normal_y;
      logic signed [NORMAL_W-1:0] normal_z;
   } req_type;

   typedef struct packed {
      logic [IRR_W-1:0] irr_red;
      logic [IRR_W-1:0] irr_green;
      logic [IRR_W-1:0] irr_blue;
      logic             normal_was_zero;
      logic             saturated;
   } rsp_type;

   // Beat information that rides alongside the normalizer.
   typedef struct packed {
      logic                      valid;
      logic                      kind;
      logic [INDEX_W-1:0]        coeff_index;
      logic signed [COEFF_W-1:0] coeff_red;
      logic signed [COEFF_W-1:0] coeff_green;
      logic signed [COEFF_W-1:0] coeff_blue;
   } tag_type;

   typedef struct packed {
      logic signed [UNIT_W-1:0] x;
      logic signed [UNIT_W-1:0] y;
      logic signed [UNIT_W-1:0] z;
      logic                     was_zero;
   } unit_type;

endpackage

### rtl/core/shie_norm.sv
module shie_norm import shie_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       enable,
   input  tag_type                    src_tag,
   input  logic signed [NORMAL_W-1:0] src_x,
   input  logic signed [NORMAL_W-1:0] src_y,
   input  logic signed [NORMAL_W-1:0] src_z,
   output tag_type                    dst_tag,
   output unit_type                   dst_unit
);

   typedef struct packed {
      logic [2:0] neg;
      logic       zero;
   } flag_type;

   localparam logic signed [UNIT_W-1:0] UNIT_ONE = UNIT_W'(1) << FRAC_W;

   tag_type  tag_ff  [NORM_LAT];
   flag_type flag_ff [NORM_LAT-1];

   // Tag line with its valid bits; the sign and zero flags are in the stage 0 block.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NORM_LAT; s++) begin
            tag_ff[s].valid <= 1'b0;
         end
      end else if (enable) begin
         tag_ff[0] <= src_tag;
         for (int s = 1; s < NORM_LAT; s++) begin
            tag_ff[s] <= tag_ff[s-1];
         end
      end
   end

   // Stage 0: magnitudes and sum of squares.
   logic signed [NORMAL_W-1:0] comp [3];
   logic [NORMAL_W-1:0]        mag  [3];
   logic [SUMSQ_W-1:0]         sumsq;
   logic [SUMSQ_W-1:0]         s0_sum_ff;
   logic [NORMAL_W-1:0]        s0_mag_ff [3];

   assign comp[0] = src_x;
   assign comp[1] = src_y;
   assign comp[2] = src_z;

   always_comb begin
      sumsq = '0;
      for (int i = 0; i < 3; i++) begin
         mag[i] = comp[i][NORMAL_W-1] ? NORMAL_W'(-comp[i]) : NORMAL_W'(comp[i]);
         sumsq  = sumsq + SUMSQ_W'(mag[i]) * SUMSQ_W'(mag[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s0_sum_ff     <= sumsq;
         s0_mag_ff     <= mag;
         flag_ff[0]    <= '{neg: {comp[2][NORMAL_W-1], comp[1][NORMAL_W-1],
                                  comp[0][NORMAL_W-1]},
                            zero: (sumsq == '0)};
         for (int s = 1; s < NORM_LAT - 1; s++) begin
            flag_ff[s] <= flag_ff[s-1];
         end
      end
   end

   // Normalizing shift: binary steps of 16, 8, 4, 2 and 1 bit pairs.
   logic [SCALED_W-1:0] sh_sum_ff [SHIFT_STEPS];
   logic [ROOT_W-1:0]   sh_mag_ff [SHIFT_STEPS][3];

   for (genvar t = 0; t < SHIFT_STEPS; t++) begin : g_shift
      localparam int M = 1 << (SHIFT_STEPS - 1 - t);
      logic [SCALED_W-1:0] sum_prev;
      logic [ROOT_W-1:0]   mag_prev [3];
      logic                fits;

      if (t == 0) begin : g_first
         assign sum_prev    = SCALED_W'(s0_sum_ff);
         assign mag_prev[0] = ROOT_W'(s0_mag_ff[0]);
         assign mag_prev[1] = ROOT_W'(s0_mag_ff[1]);
         assign mag_prev[2] = ROOT_W'(s0_mag_ff[2]);
      end else begin : g_next
         assign sum_prev = sh_sum_ff[t-1];
         assign mag_prev = sh_mag_ff[t-1];
      end

      assign fits = (sum_prev[SCALED_W-1 -: 2*M] == '0);

      always_ff @(posedge clock) begin
         if (enable) begin
            sh_sum_ff[t] <= fits ? (sum_prev << (2*M)) : sum_prev;
            for (int i = 0; i < 3; i++) begin
               sh_mag_ff[t][i] <= fits ? (mag_prev[i] << M) : mag_prev[i];
            end
         end
      end
   end

   // Square root, one result bit per stage.
   logic [SCALED_W-1:0] rt_sq_ff   [ROOT_W];
   logic [ROOT_W-1:0]   rt_root_ff [ROOT_W];
   logic [ROOT_W:0]     rt_rem_ff  [ROOT_W];
   logic [ROOT_W-1:0]   rt_mag_ff  [ROOT_W][3];

   for (genvar g = 0; g < ROOT_W; g++) begin : g_root
      localparam int BIT = ROOT_W - 1 - g;
      logic [SCALED_W-1:0] sq_prev;
      logic [ROOT_W-1:0]   root_prev;
      logic [ROOT_W:0]     rem_prev;
      logic [ROOT_W-1:0]   mag_prev [3];
      logic [ROOT_W+2:0]   cur;
      logic [ROOT_W+2:0]   trial;

      if (g == 0) begin : g_first
         assign sq_prev   = sh_sum_ff[SHIFT_STEPS-1];
         assign root_prev = '0;
         assign rem_prev  = '0;
         assign mag_prev  = sh_mag_ff[SHIFT_STEPS-1];
      end else begin : g_next
         assign sq_prev   = rt_sq_ff[g-1];
         assign root_prev = rt_root_ff[g-1];
         assign rem_prev  = rt_rem_ff[g-1];
         assign mag_prev  = rt_mag_ff[g-1];
      end

      assign cur   = {rem_prev, sq_prev[2*BIT+1 -: 2]};
      assign trial = {1'b0, root_prev, 2'b01};

      always_ff @(posedge clock) begin
         if (enable) begin
            rt_sq_ff[g]  <= sq_prev;
            rt_mag_ff[g] <= mag_prev;
            if (cur >= trial) begin
               rt_rem_ff[g]  <= (ROOT_W+1)'(cur - trial);
               rt_root_ff[g] <= {root_prev[ROOT_W-2:0], 1'b1};
            end else begin
               rt_rem_ff[g]  <= cur[ROOT_W:0];
               rt_root_ff[g] <= {root_prev[ROOT_W-2:0], 1'b0};
            end
         end
      end
   end

   // Three restoring dividers, one quotient bit per stage.
   logic [ROOT_W-1:0] dv_len_ff [QUO_W];
   logic [ROOT_W:0]   dv_rem_ff [QUO_W][3];
   logic [QUO_W-1:0]  dv_quo_ff [QUO_W][3];

   for (genvar g = 0; g < QUO_W; g++) begin : g_div
      logic [ROOT_W-1:0] len_prev;
      logic [ROOT_W:0]   cur [3];
      logic [QUO_W-1:0]  quo_prev [3];

      if (g == 0) begin : g_first
         assign len_prev = rt_root_ff[ROOT_W-1];
         for (genvar i = 0; i < 3; i++) begin : g_lane
            assign cur[i]      = {1'b0, rt_mag_ff[ROOT_W-1][i]};
            assign quo_prev[i] = '0;
         end
      end else begin : g_next
         assign len_prev = dv_len_ff[g-1];
         for (genvar i = 0; i < 3; i++) begin : g_lane
            assign cur[i]      = {dv_rem_ff[g-1][i][ROOT_W-1:0], 1'b0};
            assign quo_prev[i] = dv_quo_ff[g-1][i];
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            dv_len_ff[g] <= len_prev;
            for (int i = 0; i < 3; i++) begin
               if (cur[i] >= {1'b0, len_prev}) begin
                  dv_rem_ff[g][i] <= cur[i] - {1'b0, len_prev};
                  dv_quo_ff[g][i] <= {quo_prev[i][QUO_W-2:0], 1'b1};
               end else begin
                  dv_rem_ff[g][i] <= cur[i];
                  dv_quo_ff[g][i] <= {quo_prev[i][QUO_W-2:0], 1'b0};
               end
            end
         end
      end
   end

   // Last stage: restore signs, or fall back to straight up.
   unit_type          unit_in;
   unit_type          unit_ff;
   logic signed [UNIT_W-1:0] signed_q [3];
   flag_type          last_flag;

   assign last_flag = flag_ff[NORM_LAT-2];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         signed_q[i] = last_flag.neg[i] ? -UNIT_W'(dv_quo_ff[QUO_W-1][i])
                                        : UNIT_W'(dv_quo_ff[QUO_W-1][i]);
      end
      if (last_flag.zero) begin
         unit_in = '{x: '0, y: UNIT_ONE, z: '0, was_zero: 1'b1};
      end else begin
         unit_in = '{x: signed_q[0], y: signed_q[1], z: signed_q[2], was_zero: 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         unit_ff <= unit_in;
      end
   end

   assign dst_tag  = tag_ff[NORM_LAT-1];
   assign dst_unit = unit_ff;

endmodule

### rtl/core/sh_irradiance_eval.sv
// Channel | Direction | Handshake             | Beat
// req     | in        | req_valid / req_stall | req_data: load a coefficient or evaluate a normal
// rsp     | out       | rsp_valid / rsp_stall | rsp_data: RGB irradiance and flags, evaluate only
//
// One beat is accepted per cycle while req_stall is low; an evaluate beat passes the normalizer,
// P1 to P5 and the output register. Normalizer: a 30-stage square root and 15-stage dividers.
// Reset clears all valid bits and the nine coefficient registers.
// While a result waits with rsp_stall high, the whole pipeline holds and req_stall is high.
module sh_irradiance_eval import shie_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int PROD_W = 2 * UNIT_W;
   localparam int LIN_W  = WEIGHT_W + UNIT_W;
   localparam int QUAD_W = WEIGHT_W + PROD_W + 1;
   localparam int MAC_W  = COEFF_W + WEIGHT_W;
   localparam int SUM_W  = MAC_W + 4;

   localparam logic signed [LIN_W-1:0]  LIN_HALF  = LIN_W'(1) << (FRAC_W - 1);
   localparam logic signed [QUAD_W-1:0] QUAD_HALF = QUAD_W'(1) << (2*FRAC_W - 1);
   localparam logic signed [SUM_W-1:0]  SUM_HALF  = SUM_W'(1) << (CONST_FRAC - 1);

   logic    enable;
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   // The pipeline moves unless a finished result is held back.
   assign enable    = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !enable;

   // Normalizer.
   tag_type  src_tag;
   tag_type  nrm_tag;
   unit_type nrm_unit;

   assign src_tag = '{valid: req_valid, kind: req_data.kind,
                      coeff_index: req_data.coeff_index, coeff_red: req_data.coeff_red,
                      coeff_green: req_data.coeff_green, coeff_blue: req_data.coeff_blue};

   shie_norm u_norm (
      .clock    (clock),
      .reset    (reset),
      .enable   (enable),
      .src_tag  (src_tag),
      .src_x    (req_data.normal_x),
      .src_y    (req_data.normal_y),
      .src_z    (req_data.normal_z),
      .dst_tag  (nrm_tag),
      .dst_unit (nrm_unit)
   );

   // P1: products of normal components.
   tag_type                  p1_tag_ff;
   logic                     p1_zero_ff;
   logic signed [PROD_W-1:0] p1_xy_ff, p1_yz_ff, p1_xz_ff, p1_zz_ff;
   logic signed [PROD_W:0]   p1_diff_ff;
   logic signed [LIN_W-1:0]  p1_lx_ff, p1_ly_ff, p1_lz_ff;
   logic signed [PROD_W-1:0] sq_x, sq_y;

   assign sq_x = PROD_W'(nrm_unit.x) * PROD_W'(nrm_unit.x);
   assign sq_y = PROD_W'(nrm_unit.y) * PROD_W'(nrm_unit.y);

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_tag_ff.valid <= 1'b0;
      end else if (enable) begin
         p1_tag_ff <= nrm_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         p1_zero_ff <= nrm_unit.was_zero;
         p1_xy_ff   <= PROD_W'(nrm_unit.x) * PROD_W'(nrm_unit.y);
         p1_yz_ff   <= PROD_W'(nrm_unit.y) * PROD_W'(nrm_unit.z);
         p1_xz_ff   <= PROD_W'(nrm_unit.x) * PROD_W'(nrm_unit.z);
         p1_zz_ff   <= PROD_W'(nrm_unit.z) * PROD_W'(nrm_unit.z);
         p1_diff_ff <= (PROD_W+1)'(sq_x) - (PROD_W+1)'(sq_y);
         p1_lx_ff   <= LIN_W'(K_2C2) * LIN_W'(nrm_unit.x);
         p1_ly_ff   <= LIN_W'(K_2C2) * LIN_W'(nrm_unit.y);
         p1_lz_ff   <= LIN_W'(K_2C2) * LIN_W'(nrm_unit.z);
      end
   end

   // P2: band weights; all but the constant one are rounded half up.
   function automatic logic signed [WEIGHT_W-1:0] lin_weight(
      input logic signed [LIN_W-1:0] val
   );
      return WEIGHT_W'((val + LIN_HALF) >>> FRAC_W);
   endfunction

   function automatic logic signed [WEIGHT_W-1:0] quad_weight(
      input logic signed [QUAD_W-1:0] val
   );
      return WEIGHT_W'((val + QUAD_HALF) >>> (2*FRAC_W));
   endfunction

   tag_type                    p2_tag_ff;
   logic                       p2_zero_ff;
   logic signed [WEIGHT_W-1:0] p2_w_ff [NUM_COEFF];

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_tag_ff.valid <= 1'b0;
      end else if (enable) begin
         p2_tag_ff <= p1_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         p2_zero_ff <= p1_zero_ff;
         p2_w_ff[0] <= K_C4;
         p2_w_ff[1] <= lin_weight(p1_ly_ff);
         p2_w_ff[2] <= lin_weight(p1_lz_ff);
         p2_w_ff[3] <= lin_weight(p1_lx_ff);
         p2_w_ff[4] <= quad_weight(QUAD_W'(K_2C1) * QUAD_W'(p1_xy_ff));
         p2_w_ff[5] <= quad_weight(QUAD_W'(K_2C1) * QUAD_W'(p1_yz_ff));
         p2_w_ff[6] <= quad_weight(QUAD_W'(K_C3) * QUAD_W'(p1_zz_ff)) - K_C5;
         p2_w_ff[7] <= quad_weight(QUAD_W'(K_2C1) * QUAD_W'(p1_xz_ff));
         p2_w_ff[8] <= quad_weight(QUAD_W'(K_C1) * QUAD_W'(p1_diff_ff));
      end
   end

   // P3: coefficient table update and coefficient-weight products.
   logic signed [COEFF_W-1:0] coeff_ff [NUM_COEFF][3];
   logic                      p3_valid_ff;
   logic                      p3_zero_ff;
   logic signed [MAC_W-1:0]   p3_prod_ff [3][NUM_COEFF];
   logic                      load_hit;

   assign load_hit = p2_tag_ff.valid && (p2_tag_ff.kind == KIND_LOAD) &&
                     (p2_tag_ff.coeff_index < INDEX_W'(NUM_COEFF));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_COEFF; k++) begin
            for (int c = 0; c < 3; c++) begin
               coeff_ff[k][c] <= '0;
            end
         end
         p3_valid_ff <= 1'b0;
      end else if (enable) begin
         if (load_hit) begin
            coeff_ff[p2_tag_ff.coeff_index][0] <= p2_tag_ff.coeff_red;
            coeff_ff[p2_tag_ff.coeff_index][1] <= p2_tag_ff.coeff_green;
            coeff_ff[p2_tag_ff.coeff_index][2] <= p2_tag_ff.coeff_blue;
         end
         p3_valid_ff <= p2_tag_ff.valid && (p2_tag_ff.kind == KIND_EVAL);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         p3_zero_ff <= p2_zero_ff;
         for (int c = 0; c < 3; c++) begin
            for (int k = 0; k < NUM_COEFF; k++) begin
               p3_prod_ff[c][k] <= MAC_W'(coeff_ff[k][c]) * MAC_W'(p2_w_ff[k]);
            end
         end
      end
   end

   // P4 and P5: two-level adder tree per channel.
   logic                    p4_valid_ff, p5_valid_ff;
   logic                    p4_zero_ff, p5_zero_ff;
   logic signed [SUM_W-1:0] p4_sum_ff [3][3];
   logic signed [SUM_W-1:0] p5_acc_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         p4_valid_ff <= 1'b0;
         p5_valid_ff <= 1'b0;
      end else if (enable) begin
         p4_valid_ff <= p3_valid_ff;
         p5_valid_ff <= p4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         p4_zero_ff <= p3_zero_ff;
         p5_zero_ff <= p4_zero_ff;
         for (int c = 0; c < 3; c++) begin
            for (int g = 0; g < 3; g++) begin
               p4_sum_ff[c][g] <= SUM_W'(p3_prod_ff[c][3*g]) + SUM_W'(p3_prod_ff[c][3*g+1]) +
                                  SUM_W'(p3_prod_ff[c][3*g+2]);
            end
            p5_acc_ff[c] <= p4_sum_ff[c][0] + p4_sum_ff[c][1] + p4_sum_ff[c][2];
         end
      end
   end

   // Output stage: round, clamp at zero and saturate at the top.
   logic signed [SUM_W-1:0] rounded [3];
   logic [IRR_W-1:0]        irr     [3];
   logic [2:0]              over;
   rsp_type                 rsp_data_in;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         rounded[c] = (p5_acc_ff[c] + SUM_HALF) >>> CONST_FRAC;
         over[c]    = 1'b0;
         if (rounded[c][SUM_W-1]) begin
            irr[c] = '0;
         end else if (rounded[c] > SUM_W'(IRR_MAX)) begin
            irr[c]  = IRR_MAX;
            over[c] = 1'b1;
         end else begin
            irr[c] = IRR_W'(rounded[c]);
         end
      end
      rsp_data_in = '{irr_red: irr[0], irr_green: irr[1], irr_blue: irr[2],
                      normal_was_zero: p5_zero_ff, saturated: (over != '0)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= p5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A saturated result carries at least one channel at full scale.
   a_sat_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.saturated) |->
         (rsp_data_ff.irr_red == IRR_MAX || rsp_data_ff.irr_green == IRR_MAX ||
          rsp_data_ff.irr_blue == IRR_MAX))
      else $error("saturated flag without a full-scale channel");

   // A load beat never turns into a result.
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (enable && p2_tag_ff.valid && p2_tag_ff.kind == KIND_LOAD) |=> !p3_valid_ff)
      else $error("load beat produced a result slot");

   // A held pipeline keeps its valid bits in place.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !enable |=> ($stable(p3_valid_ff) && $stable(p4_valid_ff) && $stable(p5_valid_ff)))
      else $error("pipeline moved while stalled");

endmodule
